FILE: hw/rtl/lzd_pkg.sv
// shared constants and types of the lzss decompressor
package lzd_pkg;

  localparam int unsigned WIN_DEPTH = 4096;
  localparam int unsigned WIN_AW    = $clog2(WIN_DEPTH);
  localparam int unsigned FILL_W    = WIN_AW + 1;

  localparam logic [WIN_AW-1:0] WP_START  = 12'hfee;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_DEPTH);

  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_TOKEN = 2'd1;
  localparam logic [1:0] PH_MATCH = 2'd2;
  localparam logic [1:0] PH_SPARE = 2'd3;

  localparam logic [3:0] FLAG_BITS = 4'd8;
  localparam logic [4:0] LEN_BIAS  = 5'd3;

  typedef struct packed {
    logic              rd_en;
    logic [WIN_AW-1:0] rd_addr;
    logic              wr_en;
    logic [7:0]        wr_data;
    logic              clear;
  } win_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } byte_slot_t;

endpackage

FILE: hw/rtl/lzd_window.sv
// history window memory with fill tracking and write forwarding
module lzd_window (
  input  logic                clk,
  input  logic                rst_n,
  input  lzd_pkg::win_req_t   req,
  output logic [7:0]          rd_data
);

  logic [7:0]                   mem [lzd_pkg::WIN_DEPTH];
  logic [7:0]                   q_r;
  logic [lzd_pkg::WIN_AW-1:0]   wp_r;
  logic [lzd_pkg::WIN_AW-1:0]   wp_nxt;
  logic [lzd_pkg::FILL_W-1:0]   fill_r;
  logic [lzd_pkg::FILL_W-1:0]   fill_nxt;
  logic                         hit_r;
  logic                         vld_r;
  logic [7:0]                   fwd_data_r;
  logic [lzd_pkg::WIN_AW-1:0]   rel_addr;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wp_r] <= req.wr_data;
    end
    if (req.rd_en) begin
      q_r <= mem[req.rd_addr];
    end
  end

  // entries are written in order from the start pointer, so the fill count
  // tells which ones hold data; the others read as zero
  assign rel_addr = req.rd_addr - lzd_pkg::WP_START;

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      hit_r      <= req.wr_en && (req.rd_addr == wp_r);
      fwd_data_r <= req.wr_data;
      vld_r      <= {1'b0, rel_addr} < fill_r;
    end
  end

  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (req.clear) begin
      wp_nxt   = lzd_pkg::WP_START;
      fill_nxt = '0;
    end else if (req.wr_en) begin
      wp_nxt = wp_r + 1'b1;
      if (fill_r != lzd_pkg::FILL_FULL) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= lzd_pkg::WP_START;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign rd_data = hit_r ? fwd_data_r : (vld_r ? q_r : 8'h00);

endmodule

FILE: hw/rtl/lzd_ctrl.sv
// token parser and match copy sequencer
module lzd_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_byte,
  input  logic                    in_end,
  input  logic                    out_free,
  input  logic [7:0]              win_rd_data,
  output lzd_pkg::win_req_t       win_req,
  output lzd_pkg::byte_slot_t     slot
);

  logic [1:0]                   phase_r, phase_nxt;
  logic [7:0]                   flags_r, flags_nxt;
  logic [3:0]                   left_r, left_nxt;
  logic [7:0]                   off_low_r, off_low_nxt;
  logic [4:0]                   cnt_r, cnt_nxt;
  logic [lzd_pkg::WIN_AW-1:0]   rd_addr_r, rd_addr_nxt;
  logic                         copy_end_r, copy_end_nxt;
  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_lit_r, s1_lit_nxt;
  logic [7:0]                   s1_data_r, s1_data_nxt;
  logic                         s1_last_r, s1_last_nxt;
  logic                         s1_end_r, s1_end_nxt;
  logic                         accept;
  logic                         adv;
  logic                         issue;
  logic                         is_lit;
  logic                         is_match;
  logic [1:0]                   ph;
  logic [3:0]                   left_dec;
  logic [7:0]                   s1_byte;

  assign in_ready = (cnt_r == '0) && !s1_valid_r;
  assign accept   = in_valid && in_ready;
  assign adv      = s1_valid_r && out_free;
  assign issue    = (cnt_r != '0) && (!s1_valid_r || adv);
  assign s1_byte  = s1_lit_r ? s1_data_r : win_rd_data;

  always_comb begin
    ph = phase_r;
    if ((phase_r == lzd_pkg::PH_TOKEN && left_r == '0) || phase_r == lzd_pkg::PH_SPARE) begin
      ph = lzd_pkg::PH_FLAG;
    end
  end

  assign is_lit   = (ph == lzd_pkg::PH_TOKEN) && flags_r[0];
  assign is_match = (ph == lzd_pkg::PH_MATCH);
  assign left_dec = (left_r != '0) ? left_r - 1'b1 : left_r;

  always_comb begin
    phase_nxt    = phase_r;
    flags_nxt    = flags_r;
    left_nxt     = left_r;
    off_low_nxt  = off_low_r;
    cnt_nxt      = cnt_r;
    rd_addr_nxt  = rd_addr_r;
    copy_end_nxt = copy_end_r;
    s1_valid_nxt = s1_valid_r;
    s1_lit_nxt   = s1_lit_r;
    s1_data_nxt  = s1_data_r;
    s1_last_nxt  = s1_last_r;
    s1_end_nxt   = s1_end_r;

    if (adv) begin
      s1_valid_nxt = 1'b0;
    end

    if (issue) begin
      rd_addr_nxt  = rd_addr_r + 1'b1;
      cnt_nxt      = cnt_r - 1'b1;
      s1_valid_nxt = 1'b1;
      s1_lit_nxt   = 1'b0;
      s1_last_nxt  = (cnt_r == 5'd1);
      s1_end_nxt   = (cnt_r == 5'd1) && copy_end_r;
    end

    if (accept) begin
      case (ph)
        lzd_pkg::PH_TOKEN: begin
          if (flags_r[0]) begin
            s1_valid_nxt = 1'b1;
            s1_lit_nxt   = 1'b1;
            s1_data_nxt  = in_byte;
            s1_last_nxt  = 1'b1;
            s1_end_nxt   = in_end;
            flags_nxt    = flags_r >> 1;
            left_nxt     = left_dec;
            phase_nxt    = (left_dec == '0) ? lzd_pkg::PH_FLAG : lzd_pkg::PH_TOKEN;
          end else begin
            off_low_nxt = in_byte;
            phase_nxt   = lzd_pkg::PH_MATCH;
          end
        end
        lzd_pkg::PH_MATCH: begin
          rd_addr_nxt  = {in_byte[3:0], off_low_r};
          cnt_nxt      = {1'b0, in_byte[7:4]} + lzd_pkg::LEN_BIAS;
          copy_end_nxt = in_end;
          flags_nxt    = flags_r >> 1;
          left_nxt     = left_dec;
          phase_nxt    = (left_dec == '0) ? lzd_pkg::PH_FLAG : lzd_pkg::PH_TOKEN;
        end
        default: begin
          flags_nxt = in_byte;
          left_nxt  = lzd_pkg::FLAG_BITS;
          phase_nxt = lzd_pkg::PH_TOKEN;
        end
      endcase
      if (in_end) begin
        phase_nxt   = lzd_pkg::PH_FLAG;
        flags_nxt   = '0;
        left_nxt    = '0;
        off_low_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= lzd_pkg::PH_FLAG;
      flags_r    <= '0;
      left_r     <= '0;
      off_low_r  <= '0;
      cnt_r      <= '0;
      copy_end_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      flags_r    <= flags_nxt;
      left_r     <= left_nxt;
      off_low_r  <= off_low_nxt;
      cnt_r      <= cnt_nxt;
      copy_end_r <= copy_end_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    s1_lit_r  <= s1_lit_nxt;
    s1_data_r <= s1_data_nxt;
    s1_last_r <= s1_last_nxt;
    s1_end_r  <= s1_end_nxt;
  end

  always_comb begin
    win_req.rd_en   = issue;
    win_req.rd_addr = rd_addr_r;
    win_req.wr_en   = adv;
    win_req.wr_data = s1_byte;
    win_req.clear   = (adv && s1_end_r) || (accept && in_end && !is_lit && !is_match);
  end

  always_comb begin
    slot.valid = s1_valid_r;
    slot.data  = s1_byte;
    slot.last  = s1_last_r;
  end

endmodule

FILE: hw/rtl/lzss_decompressor_unit.sv
// top level of the lzss decompressor
// Takes one compressed byte per input transfer and gives decompressed bytes one per
// output transfer, tlast marking the final byte caused by an input byte. A flag byte
// or the first byte of a match is taken and gives no output; a literal gives one byte;
// a match gives 3 to 18 bytes read from the 4096-byte history window, which has a
// single read port and yields one byte per cycle while the output is not stalled.
// An input byte with tlast set ends the stream: after its output the window reads
// as all zero and parsing starts over, with no clearing pause.
module lzss_decompressor_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // comp_byte
  input  logic       in_tlast,   // stream_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic       out_tlast   // last_of_run
);

  lzd_pkg::win_req_t   win_req;
  lzd_pkg::byte_slot_t slot;
  logic [7:0]          win_rd_data;
  logic                out_free;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_data_r;
  logic                out_last_r;

  assign out_free = !out_valid_r || out_tready;

  lzd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_byte     (in_tdata),
    .in_end      (in_tlast),
    .out_free    (out_free),
    .win_rd_data (win_rd_data),
    .win_req     (win_req),
    .slot        (slot)
  );

  lzd_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (win_req),
    .rd_data (win_rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = slot.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && slot.valid) begin
      out_data_r <= slot.data;
      out_last_r <= slot.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hw/rtl/lzd_port_checker.sv
// port checks for the lzss decompressor, bound to the top level
module lzd_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("out payload changed while stalled");

  // no new input while a run is still being delivered
  a_run_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a run");

  // bytes of one run follow without gaps
  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside an output run");

endmodule

bind lzss_decompressor_unit lzd_port_checker u_lzd_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
